### design/ovl_pkg.sv
package ovl_pkg;

   // Command codes carried on req_command.
   localparam logic [2:0] CMD_APPEND      = 3'd0;
   localparam logic [2:0] CMD_REMOVE_HEAD = 3'd1;
   localparam logic [2:0] CMD_REMOVE      = 3'd2;
   localparam logic [2:0] CMD_SEARCH      = 3'd3;
   localparam logic [2:0] CMD_CLEAR       = 3'd4;

   // Status codes returned on rsp_status.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } ovl_state_type;

   // Broadcast controls from the sequencer to every cell of the chain.
   typedef struct packed {
      logic append_en;   // the first free cell, at index count, captures the key
      logic shift_en;    // cells at or above shift_from take their upper neighbor
      logic scan_start;  // place the probe token in the first cell
      logic scan_step;   // move the probe token one cell toward the tail
   } ovl_cell_ctrl_type;

endpackage

### design/ovl_cell.sv
module ovl_cell #(
   parameter int unsigned CW = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ovl_pkg::ovl_cell_ctrl_type ctrl,
   input  logic [CW-1:0]             cell_index,
   input  logic [CW-1:0]             count,
   input  logic [CW-1:0]             shift_from,
   input  logic [31:0]               key,
   input  logic [31:0]               next_entry,
   input  logic                      prev_probe,
   output logic [31:0]               entry,
   output logic                      probe,
   output logic                      hit
);

   logic [31:0] entry_ff;
   logic [31:0] entry_in;
   logic        probe_ff;
   logic        probe_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.append_en && (cell_index == count)) begin
         entry_in = key;
      end else if (ctrl.shift_en && (cell_index >= shift_from)) begin
         entry_in = next_entry;
      end
   end

   // The probe token marks the one cell whose entry is compared this cycle.
   always_comb begin
      probe_in = probe_ff;
      if (ctrl.scan_start) begin
         probe_in = (cell_index == '0);
      end else if (ctrl.scan_step) begin
         probe_in = prev_probe;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= 1'b0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign entry = entry_ff;
   assign probe = probe_ff;
   assign hit   = probe_ff && (entry_ff == key);

endmodule

### design/ordered_value_list.sv
// Ordered list of up to DEPTH signed 32-bit values, head first, kept in a chain of cells that
// each hold one entry. A beat on the req_ channel carries a command and a value; every command
// returns exactly one rsp_ beat with a status, a position and the entry count after the command.
// The block works on one command at a time and holds req_stall high after an accepted beat until
// its response beat has been taken. For append, remove head, clear, the unused command codes,
// and search or remove value on an empty list, the response is offered in the cycle after the
// request beat. Search and remove value walk a probe token along the chain, one cell per cycle,
// from the head until the first match or until the last entry has been probed, and then offer
// the response. Removal closes the gap at once, since the removed cell and every cell above it
// take their upper neighbor's entry together. After reset the list is empty and the block
// accepts a command as soon as reset is released.
module ordered_value_list #(
   parameter int unsigned DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_value,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_position,
   output logic [8:0]         rsp_count
);

   localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   // Sequencer registers.
   ovl_pkg::ovl_state_type state_ff;
   ovl_pkg::ovl_state_type state_in;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic [IW-1:0]          ptr_ff;
   logic [IW-1:0]          ptr_in;
   logic [31:0]            key_ff;
   logic [31:0]            key_in;
   logic                   remove_ff;
   logic                   remove_in;
   logic [1:0]             status_ff;
   logic [1:0]             status_in;
   logic [7:0]             position_ff;
   logic [7:0]             position_in;

   // Chain wiring.
   ovl_pkg::ovl_cell_ctrl_type cell_ctrl;
   logic [CW-1:0]              shift_from;
   logic [31:0]                cell_key;
   logic [31:0]                entries [DEPTH];
   logic [DEPTH-1:0]           probes;
   logic [DEPTH-1:0]           hits;

   // Shared conditions used by the next-state and the control logic.
   logic accept;
   logic list_empty;
   logic list_full;
   logic hit_any;
   logic scan_last;
   logic starts_scan;

   assign accept      = req_valid && !req_stall;
   assign list_empty  = (count_ff == '0);
   assign list_full   = (count_ff == CW'(DEPTH));
   assign hit_any     = |hits;
   assign scan_last   = ((CW'(ptr_ff) + CW'(1)) == count_ff);
   assign starts_scan = ((req_command == ovl_pkg::CMD_REMOVE) ||
                         (req_command == ovl_pkg::CMD_SEARCH)) && !list_empty;

   // While idle the incoming value goes straight to the cells so that an append lands in the
   // same edge that accepts it; during a walk the latched key is compared instead.
   assign cell_key = (state_ff == ovl_pkg::ST_IDLE) ? req_value : key_ff;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ovl_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = starts_scan ? ovl_pkg::ST_SCAN : ovl_pkg::ST_RESP;
            end
         end
         ovl_pkg::ST_SCAN: begin
            if (hit_any || scan_last) begin
               state_in = ovl_pkg::ST_RESP;
            end
         end
         ovl_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ovl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ovl_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and datapath updates for each state.
   always_comb begin
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      key_in      = key_ff;
      remove_in   = remove_ff;
      status_in   = status_ff;
      position_in = position_ff;
      shift_from  = '0;
      cell_ctrl   = '0;

      case (state_ff)
         ovl_pkg::ST_IDLE: begin
            if (accept) begin
               status_in   = ovl_pkg::STATUS_OK;
               position_in = '0;
               case (req_command)
                  ovl_pkg::CMD_APPEND: begin
                     if (list_full) begin
                        status_in = ovl_pkg::STATUS_FULL;
                     end else begin
                        cell_ctrl.append_en = 1'b1;
                        count_in            = count_ff + CW'(1);
                     end
                  end
                  ovl_pkg::CMD_REMOVE_HEAD: begin
                     if (list_empty) begin
                        status_in = ovl_pkg::STATUS_EMPTY;
                     end else begin
                        cell_ctrl.shift_en = 1'b1;
                        count_in           = count_ff - CW'(1);
                     end
                  end
                  ovl_pkg::CMD_REMOVE, ovl_pkg::CMD_SEARCH: begin
                     if (list_empty) begin
                        status_in = ovl_pkg::STATUS_EMPTY;
                     end else begin
                        cell_ctrl.scan_start = 1'b1;
                        ptr_in               = '0;
                        key_in               = req_value;
                        remove_in            = (req_command == ovl_pkg::CMD_REMOVE);
                     end
                  end
                  ovl_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     // Unused codes leave the list alone and report success.
                  end
               endcase
            end
         end
         ovl_pkg::ST_SCAN: begin
            if (hit_any) begin
               status_in   = ovl_pkg::STATUS_OK;
               position_in = 8'(ptr_ff);
               if (remove_ff) begin
                  cell_ctrl.shift_en = 1'b1;
                  shift_from         = CW'(ptr_ff);
                  count_in           = count_ff - CW'(1);
               end
            end else if (scan_last) begin
               status_in   = ovl_pkg::STATUS_NOT_FOUND;
               position_in = '0;
            end else begin
               cell_ctrl.scan_step = 1'b1;
               ptr_in              = ptr_ff + IW'(1);
            end
         end
         ovl_pkg::ST_RESP: begin
            // Hold the response until the downstream side takes it.
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ovl_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      key_ff      <= key_in;
      remove_ff   <= remove_in;
      status_ff   <= status_in;
      position_ff <= position_in;
   end

   // The chain: cell 0 holds the head, and each cell hands its entry down to the cell below
   // when a removal closes the gap, and its probe token up to the next cell during a walk.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [31:0] next_entry;
      logic        prev_probe;

      if (i == DEPTH - 1) begin : g_tail
         assign next_entry = entries[i];
      end else begin : g_body
         assign next_entry = entries[i+1];
      end

      if (i == 0) begin : g_head
         assign prev_probe = 1'b0;
      end else begin : g_link
         assign prev_probe = probes[i-1];
      end

      ovl_cell #(
         .CW (CW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .cell_index (CW'(i)),
         .count      (count_ff),
         .shift_from (shift_from),
         .key        (cell_key),
         .next_entry (next_entry),
         .prev_probe (prev_probe),
         .entry      (entries[i]),
         .probe      (probes[i]),
         .hit        (hits[i])
      );
   end

   // The count register already holds the post-command value while the response is offered.
   assign req_stall    = (state_ff != ovl_pkg::ST_IDLE);
   assign rsp_valid    = (state_ff == ovl_pkg::ST_RESP);
   assign rsp_status   = status_ff;
   assign rsp_position = position_ff;
   assign rsp_count    = 9'(count_ff);

endmodule

### design/ovl_checker.sv
module ovl_checker #(
   parameter int unsigned DEPTH = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_status,
   input logic [7:0]         rsp_position,
   input logic [8:0]         rsp_count
);

   // A response that waits keeps its contents.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
                                 $stable(rsp_position) && $stable(rsp_count))
      else $error("response changed while stalled");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= 9'(DEPTH)))
      else $error("entry count above list depth");

   a_miss_position : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ovl_pkg::STATUS_OK) |-> (rsp_position == 8'd0))
      else $error("nonzero position on a failed command");

   a_empty_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ovl_pkg::STATUS_EMPTY) |-> (rsp_count == 9'd0))
      else $error("empty status with entries held");

   a_full_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ovl_pkg::STATUS_FULL) |-> (rsp_count == 9'(DEPTH)))
      else $error("full status with free room");

endmodule

bind ordered_value_list ovl_checker #(.DEPTH(DEPTH)) u_ovl_checker (.*);
